/* rtl/urd_pkg.sv */
// Shared types and constants for the unsigned-to-radix-digits converter.
// Used by urd_ctrl, urd_datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package urd_pkg;

   // alphabet register file
   localparam int NUM_WORDS   = 8;
   localparam int WORD_W      = 64;
   localparam int SYM_W       = 8;
   localparam int ALPHA_BYTES = 64;
   localparam int ALPHA_IDX_W = 6;
   localparam int CSR_IDX_W   = 8;
   localparam int WORD_SEL_W  = 3;

   // input value width of the port
   localparam int IN_W = 64;

   // bits of dividend retired per divider cycle
   localparam int BITS_PER_STEP = 8;

   // defaults for the top-level parameters
   localparam int DEF_VALUE_WIDTH = 64;
   localparam int DEF_MAX_SYMBOLS = 64;

   // special symbols
   localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;
   localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
   localparam logic [SYM_W-1:0] SYM_END   = 8'h00;

   // reset alphabet "0123456789abcdef"
   localparam logic [WORD_W-1:0] RESET_WORD_0 = 64'h3736353433323130;
   localparam logic [WORD_W-1:0] RESET_WORD_1 = 64'h6665646362613938;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;       // capture the value, restart the alphabet scan
      logic scan_sel;   // symbol lookup addressed by the scan position
      logic scan_step;  // advance the scan position
      logic div_init;   // latch the base, clear the digit count
      logic div_step;   // retire one group of dividend bits
      logic store;      // save the remainder as a digit, start next digit
      logic emit;       // read out one stored digit
      logic error;      // send the bad-alphabet result
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic scan_end;    // terminator found or symbol limit reached
      logic scan_bad;    // sign symbol or repeated symbol at this position
      logic scan_short;  // fewer than two symbols so far
      logic div_last;    // this divider cycle finishes the digit
      logic quot_zero;   // quotient is zero after the digit
      logic emit_final;  // this read is the least significant digit
   } status_type;

endpackage

/* rtl/unsigned_to_radix_digits.sv */
// Top level of the unsigned-to-radix-digits converter.
// Instantiates urd_ctrl and urd_datapath; uses urd_pkg.
`timescale 1ns / 1ps

// Converts one unsigned value per command into digit symbols, most
// significant first, in the base given by the length of the configured
// alphabet (zero byte ends it). An item is taken when start is high and busy
// is low. Results appear one per cycle on the rsp_ ports, each marked by
// rsp_valid for a single cycle; the receiver must take them as they come.
// Per item the block first checks the alphabet, one symbol per cycle against
// all earlier ones, then computes each digit in the shared divider, which
// retires eight dividend bits per cycle, then reads the digits back from the
// digit memory and drains; a bad alphabet ends after the scan with a single
// result. The user must write the alphabet registers through csr_ only while
// the block is idle; the block itself does not enforce this.

module unsigned_to_radix_digits
   import urd_pkg::*;
#(
   parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
   parameter int MAX_SYMBOLS = DEF_MAX_SYMBOLS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [IN_W-1:0]      req_value,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]    csr_data,
   output logic                 rsp_valid,
   output logic [SYM_W-1:0]     rsp_symbol,
   output logic                 rsp_last_digit,
   output logic                 rsp_bad_alphabet
);

   cmd_type    cmd;
   status_type status;

   // sequence the conversion
   urd_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   // hold the alphabet, divide and buffer digits
   urd_datapath #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .MAX_SYMBOLS (MAX_SYMBOLS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_value        (req_value),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .rsp_valid        (rsp_valid),
      .rsp_symbol       (rsp_symbol),
      .rsp_last_digit   (rsp_last_digit),
      .rsp_bad_alphabet (rsp_bad_alphabet)
   );

endmodule

/* rtl/urd_ctrl.sv */
// Controller of the unsigned-to-radix-digits converter: sequences the
// alphabet scan, the digit divisions and the digit read-out. Uses urd_pkg.
`timescale 1ns / 1ps

module urd_ctrl
   import urd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  status_type status,
   output cmd_type    cmd,
   output logic       busy
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN  = 3'd1;
   localparam logic [2:0] ST_DIV   = 3'd2;
   localparam logic [2:0] ST_STORE = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;
   localparam logic [2:0] ST_DRAIN = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign busy = (state_ff != ST_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_sel = 1'b1;
            if (status.scan_end) begin
               if (status.scan_short) begin
                  cmd.error = 1'b1;
                  state_in  = ST_IDLE;
               end else begin
                  cmd.div_init = 1'b1;
                  state_in     = ST_DIV;
               end
            end else if (status.scan_bad) begin
               cmd.error = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            cmd.store = 1'b1;
            state_in  = status.quot_zero ? ST_EMIT : ST_DIV;
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            if (status.emit_final) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef ASSERT_OFF
   // a new item is only taken from idle
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> $past(state_ff) != ST_SCAN || !busy || state_ff == ST_IDLE)
      else $error("load outside idle");

   // the last digit read is followed by the drain state, then idle
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && status.emit_final) |=> (state_ff == ST_DRAIN) ##1 !busy)
      else $error("read-out did not drain to idle");

   // a finished division always stores its digit next
   a_store: assert property (@(posedge clock) disable iff (reset)
      (cmd.div_step && status.div_last) |=> cmd.store)
      else $error("division finished without storing the digit");
`endif

endmodule

/* rtl/urd_datapath.sv */
// Datapath of the unsigned-to-radix-digits converter: alphabet registers,
// alphabet checker, iterative divider, digit memory and result register.
// Uses urd_pkg; driven by urd_ctrl.
`timescale 1ns / 1ps

module urd_datapath
   import urd_pkg::*;
#(
   parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
   parameter int MAX_SYMBOLS = DEF_MAX_SYMBOLS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output status_type           status,
   input  logic [IN_W-1:0]      req_value,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]    csr_data,
   output logic                 rsp_valid,
   output logic [SYM_W-1:0]     rsp_symbol,
   output logic                 rsp_last_digit,
   output logic                 rsp_bad_alphabet
);

   localparam int REM_W      = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
   localparam int BASE_W     = $clog2(MAX_SYMBOLS + 1);
   localparam int DIV_CYCLES = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
   localparam int PAD_W      = DIV_CYCLES * BITS_PER_STEP;
   localparam int STEP_W     = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
   localparam int DEPTH      = VALUE_WIDTH;
   localparam int IDX_W      = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int POS_CMP_W  = ALPHA_IDX_W + 1;

   // alphabet register file
   logic [WORD_W-1:0] word_ff [NUM_WORDS];

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff[0] <= RESET_WORD_0;
         word_ff[1] <= RESET_WORD_1;
         for (int w = 2; w < NUM_WORDS; w++) begin
            word_ff[w] <= '0;
         end
      end else if (csr_write_enable && (csr_index < CSR_IDX_W'(NUM_WORDS))) begin
         word_ff[csr_index[WORD_SEL_W-1:0]] <= csr_data;
      end
   end

   // unpack the alphabet into bytes
   logic [SYM_W-1:0] sym [ALPHA_BYTES];

   always_comb begin
      for (int b = 0; b < ALPHA_BYTES; b++) begin
         sym[b] = word_ff[b / 8][(b % 8) * SYM_W +: SYM_W];
      end
   end

   // working registers
   logic [BASE_W-1:0] pos_ff, pos_in;
   logic [BASE_W-1:0] base_ff, base_in;
   logic [PAD_W-1:0]  num_ff, num_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [REM_W-1:0]  digit_ff;
   logic              pend_valid_ff, pend_last_ff;
   logic              rsp_valid_ff, rsp_last_ff, rsp_bad_ff;
   logic [SYM_W-1:0]  rsp_symbol_ff;

   // shared symbol lookup: scan position, or the digit being read out
   logic [ALPHA_IDX_W-1:0] sym_addr;
   logic [SYM_W-1:0]       cur_sym;
   logic                   dup_hit;

   assign sym_addr = cmd.scan_sel ? ALPHA_IDX_W'(pos_ff) : ALPHA_IDX_W'(digit_ff);
   assign cur_sym  = sym[sym_addr];

   // compare the current symbol against all earlier ones
   always_comb begin
      dup_hit = 1'b0;
      for (int j = 0; j < ALPHA_BYTES; j++) begin
         if ((POS_CMP_W'(j) < POS_CMP_W'(pos_ff)) && (sym[j] == cur_sym)) begin
            dup_hit = 1'b1;
         end
      end
   end

   assign status.scan_end   = (pos_ff == BASE_W'(MAX_SYMBOLS)) || (cur_sym == SYM_END);
   assign status.scan_bad   = (cur_sym == SYM_MINUS) || (cur_sym == SYM_PLUS) || dup_hit;
   assign status.scan_short = (pos_ff < BASE_W'(2));
   assign status.div_last   = (step_ff == STEP_W'(DIV_CYCLES - 1));
   assign status.quot_zero  = (num_ff == '0);
   assign status.emit_final = (count_ff == CNT_W'(1));

   // one divider cycle: restoring division, one bit per inner step
   logic [PAD_W-1:0]  div_num;
   logic [REM_W-1:0]  div_rem;
   logic [REM_W:0]    trial;

   always_comb begin
      div_num = num_ff;
      div_rem = rem_ff;
      trial   = '0;
      for (int k = 0; k < BITS_PER_STEP; k++) begin
         trial   = {div_rem, div_num[PAD_W-1]};
         div_num = {div_num[PAD_W-2:0], 1'b0};
         if (trial >= (REM_W+1)'(base_ff)) begin
            trial      = trial - (REM_W+1)'(base_ff);
            div_num[0] = 1'b1;
         end
         div_rem = trial[REM_W-1:0];
      end
   end

   // next values of the working registers
   always_comb begin
      pos_in   = pos_ff;
      base_in  = base_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      step_in  = step_ff;
      count_in = count_ff;
      if (cmd.load) begin
         pos_in = '0;
         num_in = PAD_W'(req_value[VALUE_WIDTH-1:0]);
      end
      if (cmd.scan_step) begin
         pos_in = pos_ff + 1'b1;
      end
      if (cmd.div_init) begin
         base_in  = pos_ff;
         rem_in   = '0;
         step_in  = '0;
         count_in = '0;
      end
      if (cmd.div_step) begin
         num_in  = div_num;
         rem_in  = div_rem;
         step_in = step_ff + 1'b1;
      end
      if (cmd.store) begin
         rem_in   = '0;
         step_in  = '0;
         count_in = count_ff + 1'b1;
      end
      if (cmd.emit) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff   <= pos_in;
      base_ff  <= base_in;
      num_ff   <= num_in;
      rem_ff   <= rem_in;
      step_ff  <= step_in;
      count_ff <= count_in;
   end

   // digit memory, least significant digit at address 0
   logic [REM_W-1:0] digit_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (cmd.store) begin
         digit_mem[count_ff[IDX_W-1:0]] <= rem_ff;
      end
      if (cmd.emit) begin
         digit_ff <= digit_mem[IDX_W'(count_ff - 1'b1)];
      end
   end

   // read-out pipeline marks
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         pend_last_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= cmd.emit;
         pend_last_ff  <= cmd.emit && status.emit_final;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= pend_valid_ff || cmd.error;
      end
      if (cmd.error) begin
         rsp_symbol_ff <= SYM_END;
         rsp_last_ff   <= 1'b1;
         rsp_bad_ff    <= 1'b1;
      end else begin
         rsp_symbol_ff <= cur_sym;
         rsp_last_ff   <= pend_last_ff;
         rsp_bad_ff    <= 1'b0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_symbol       = rsp_symbol_ff;
   assign rsp_last_digit   = rsp_last_ff;
   assign rsp_bad_alphabet = rsp_bad_ff;

`ifndef ASSERT_OFF
   // an error result is always the final one
   a_bad_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_bad_ff) |-> rsp_last_ff)
      else $error("bad-alphabet result not flagged last");

   // the partial remainder stays below the base
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> (BASE_W+REM_W)'(rem_ff) < (BASE_W+REM_W)'(base_ff))
      else $error("remainder out of range");

   // the digit memory never overflows
   a_depth: assert property (@(posedge clock) disable iff (reset)
      cmd.store |-> count_ff < CNT_W'(DEPTH))
      else $error("digit memory overflow");

   // nothing is read out after the final digit
   a_final: assert property (@(posedge clock) disable iff (reset)
      (pend_valid_ff && pend_last_ff) |=> !pend_valid_ff)
      else $error("digit read after the final one");
`endif

endmodule
